// ===== rtl/core/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, the datapath operation codes
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_WIDTH  = 16;
    localparam int FILL_WIDTH = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_DROP,
        OP_EMPTY
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic is_dequeue;
        logic empty;
        logic full;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/spq_ctrl.sv =====
// Controller of the sorted priority queue: takes a transaction, then picks
// the datapath operation from the latched action and the fill status.
// Depends on spq_pkg.
`default_nettype none

module spq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  spq_pkg::t_status  i_status,
    output spq_pkg::t_cmd     o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && start;
        o_cmd.op   = spq_pkg::OP_NONE;
        if (r_state == S_EXEC) begin
            if (i_status.is_dequeue) begin
                o_cmd.op = i_status.empty ? spq_pkg::OP_EMPTY : spq_pkg::OP_REMOVE;
            end else begin
                o_cmd.op = i_status.full ? spq_pkg::OP_DROP : spq_pkg::OP_INSERT;
            end
        end
    end

    assign busy = r_busy;

`ifndef NO_ASSERTIONS
    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (o_cmd.op != spq_pkg::OP_NONE))
        else $error("accepted transaction was not executed in the next cycle");
    a_no_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cmd.load)
        else $error("transaction loaded while busy");
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/spq_dpath.sv =====
// Datapath of the sorted priority queue: a row of compare-and-shift cells
// holding the keys in ascending order, the fill counter and the result registers.
// Depends on spq_pkg.
`default_nettype none

module spq_dpath (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  spq_pkg::t_cmd                           i_cmd,
    output spq_pkg::t_status                        o_status,
    input  wire                                     i_action,
    input  wire signed [spq_pkg::KEY_WIDTH-1:0]     i_key_in,
    output logic                                    o_done,
    output logic signed [spq_pkg::KEY_WIDTH-1:0]    o_key_out,
    output logic                                    o_key_valid,
    output logic                                    o_underflow,
    output logic                                    o_overflow,
    output logic [spq_pkg::FILL_WIDTH-1:0]          o_fill_level
);

    logic                                   r_action;
    logic signed [spq_pkg::KEY_WIDTH-1:0]   r_key;
    logic signed [spq_pkg::KEY_WIDTH-1:0]   r_cells [spq_pkg::CAPACITY];
    logic signed [spq_pkg::KEY_WIDTH-1:0]   n_cells [spq_pkg::CAPACITY];
    logic [spq_pkg::FILL_WIDTH-1:0]         r_count;
    logic [spq_pkg::CAPACITY-1:0]           w_le;
    logic                                   r_done;
    logic signed [spq_pkg::KEY_WIDTH-1:0]   r_key_out;
    logic                                   r_key_valid;
    logic                                   r_underflow;
    logic                                   r_overflow;

    // A cell whose stored key is less than or equal to the new key stays put;
    // the first cell that is not takes the new key, and the rest shift up.
    for (genvar g = 0; g < spq_pkg::CAPACITY; g++) begin : g_cell
        assign w_le[g] = (r_count > spq_pkg::FILL_WIDTH'(g)) && (r_cells[g] <= r_key);

        always_comb begin
            n_cells[g] = r_cells[g];
            if (i_cmd.op == spq_pkg::OP_INSERT) begin
                if (!w_le[g]) begin
                    if (g == 0) begin
                        n_cells[g] = r_key;
                    end else if (w_le[(g == 0) ? 0 : g - 1]) begin
                        n_cells[g] = r_key;
                    end else begin
                        n_cells[g] = r_cells[(g == 0) ? 0 : g - 1];
                    end
                end
            end else if (i_cmd.op == spq_pkg::OP_REMOVE) begin
                if (g < spq_pkg::CAPACITY - 1) begin
                    n_cells[g] = r_cells[(g < spq_pkg::CAPACITY - 1) ? g + 1 : g];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_cells[g] <= n_cells[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_key    <= i_key_in;
        end
        r_key_out <= (i_cmd.op == spq_pkg::OP_REMOVE) ? r_cells[0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_done      <= 1'b0;
            r_key_valid <= 1'b0;
            r_underflow <= 1'b0;
            r_overflow  <= 1'b0;
        end else begin
            r_done      <= (i_cmd.op != spq_pkg::OP_NONE);
            r_key_valid <= (i_cmd.op == spq_pkg::OP_REMOVE);
            r_underflow <= (i_cmd.op == spq_pkg::OP_EMPTY);
            r_overflow  <= (i_cmd.op == spq_pkg::OP_DROP);
            case (i_cmd.op)
                spq_pkg::OP_INSERT: r_count <= r_count + 1'b1;
                spq_pkg::OP_REMOVE: r_count <= r_count - 1'b1;
                default:            r_count <= r_count;
            endcase
        end
    end

    assign o_status.is_dequeue = r_action;
    assign o_status.empty      = (r_count == '0);
    assign o_status.full       = (r_count == spq_pkg::FILL_WIDTH'(spq_pkg::CAPACITY));

    assign o_done       = r_done;
    assign o_key_out    = r_key_out;
    assign o_key_valid  = r_key_valid;
    assign o_underflow  = r_underflow;
    assign o_overflow   = r_overflow;
    assign o_fill_level = r_count;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::FILL_WIDTH'(spq_pkg::CAPACITY))
        else $error("fill count above capacity");
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $onehot0({r_key_valid, r_underflow, r_overflow}))
        else $error("more than one outcome flag in a result");
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == spq_pkg::OP_REMOVE) |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not lower the fill count by one");
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_underflow |-> (r_count == '0))
        else $error("underflow reported with keys stored");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sorted_priority_queue.sv =====
// Min-first priority queue over a row of sorted compare-and-shift cells.
// A transaction is latched on acceptance, executed in the controller's EXEC
// state, and its result strobe o_done is registered from that execution;
// busy is high while the controller is in EXEC, during which no new
// transaction is taken. The receiver cannot stall the result.
// Synchronous active-low reset empties the queue; stored keys are not cleared.
`default_nettype none

module sorted_priority_queue (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     start,
    output logic                                    busy,
    input  wire                                     i_action,
    input  wire signed [spq_pkg::KEY_WIDTH-1:0]     i_key_in,
    output logic                                    o_done,
    output logic signed [spq_pkg::KEY_WIDTH-1:0]    o_key_out,
    output logic                                    o_key_valid,
    output logic                                    o_underflow,
    output logic                                    o_overflow,
    output logic [spq_pkg::FILL_WIDTH-1:0]          o_fill_level
);

    spq_pkg::t_cmd    w_cmd;
    spq_pkg::t_status w_status;

    spq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    spq_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_action     (i_action),
        .i_key_in     (i_key_in),
        .o_done       (o_done),
        .o_key_out    (o_key_out),
        .o_key_valid  (o_key_valid),
        .o_underflow  (o_underflow),
        .o_overflow   (o_overflow),
        .o_fill_level (o_fill_level)
    );

endmodule

`default_nettype wire

// ===== verif/sorted_priority_queue_tb.sv =====
// Self-checking testbench for the min-first sorted priority queue.
// Drives enqueue and dequeue transactions in bursts and checks each result
// against a queue model kept here. Depends on spq_pkg and the RTL top level.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

    localparam int KW = spq_pkg::KEY_WIDTH;
    localparam int FW = spq_pkg::FILL_WIDTH;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    localparam int RANDOM_TXNS  = 450;
    localparam int TAIL_CYCLES  = 4;
    localparam int DRAIN_LIMIT  = 1000;
    localparam int TIMEOUT_NS   = 400_000;
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [KW-1:0] KEY_MIN = {1'b1, {(KW-1){1'b0}}};
    localparam logic signed [KW-1:0] KEY_MAX = {1'b0, {(KW-1){1'b1}}};

    typedef struct packed {
        logic signed [KW-1:0] key_out;
        logic                 key_valid;
        logic                 underflow;
        logic                 overflow;
        logic [FW-1:0]        fill_level;
    } t_pq_result;

    typedef struct {
        logic                 action;
        logic signed [KW-1:0] key;
        bit                   typed;
        t_pq_result           result;
    } t_directed_row;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic                 i_action     = 1'b0;
    logic signed [KW-1:0] i_key_in     = '0;
    logic                 busy;
    logic                 o_done;
    logic signed [KW-1:0] o_key_out;
    logic                 o_key_valid;
    logic                 o_underflow;
    logic                 o_overflow;
    logic [FW-1:0]        o_fill_level;

    // Queue model state.
    logic signed [KW-1:0] model_keys [spq_pkg::CAPACITY];
    int                   model_count = 0;

    t_pq_result    pending_results [$];
    t_directed_row directed_rows [$];

    int mismatches    = 0;
    int txn_count     = 0;
    int keys_returned = 0;
    int underflows    = 0;
    int overflows     = 0;
    int burst_left    = 0;

    sorted_priority_queue DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_key_in     (i_key_in),
        .o_done       (o_done),
        .o_key_out    (o_key_out),
        .o_key_valid  (o_key_valid),
        .o_underflow  (o_underflow),
        .o_overflow   (o_overflow),
        .o_fill_level (o_fill_level)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one transaction to the model and returns its result.
    function automatic t_pq_result apply_to_model(input logic action,
                                                  input logic signed [KW-1:0] key);
        t_pq_result res;
        int         pos;
        res = '0;
        if (action == ACT_ENQUEUE) begin
            if (model_count >= spq_pkg::CAPACITY) begin
                res.overflow = 1'b1;
                overflows++;
            end else begin
                pos = 0;
                // Equal keys go behind the ones already stored.
                while (pos < model_count && key >= model_keys[pos]) pos++;
                for (int i = model_count; i > pos; i--) model_keys[i] = model_keys[i-1];
                model_keys[pos] = key;
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                res.underflow = 1'b1;
                underflows++;
            end else begin
                res.key_out   = model_keys[0];
                res.key_valid = 1'b1;
                for (int i = 1; i < model_count; i++) model_keys[i-1] = model_keys[i];
                model_count--;
                keys_returned++;
            end
        end
        res.fill_level = FW'(model_count);
        return res;
    endfunction

    function automatic void flag_mismatch(input string field, input int exp_v,
                                          input int got_v);
        if (mismatches < REPORT_LIMIT)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field,
                     exp_v, got_v);
        mismatches++;
    endfunction

    function automatic void add_row(input logic action, input logic signed [KW-1:0] key,
                                    input int typed, input logic signed [KW-1:0] key_out,
                                    input int key_valid, input int underflow,
                                    input int overflow, input int fill);
        t_directed_row row;
        row.action            = action;
        row.key               = key;
        row.typed             = (typed != 0);
        row.result.key_out    = key_out;
        row.result.key_valid  = 1'(key_valid);
        row.result.underflow  = 1'(underflow);
        row.result.overflow   = 1'(overflow);
        row.result.fill_level = FW'(fill);
        directed_rows.push_back(row);
    endfunction

    // Keys from a narrow band in three draws of ten, and the two extremes in two, so that duplicates are common.
    function automatic logic signed [KW-1:0] pick_key();
        logic signed [KW-1:0] key;
        case ($urandom_range(0, 9))
            0:       key = KEY_MIN;
            1:       key = KEY_MAX;
            2, 3, 4: key = KW'($signed($urandom_range(0, 15)) - 8);
            default: key = KW'($urandom);
        endcase
        return key;
    endfunction

    // Presents one transaction and returns at the edge where it is taken.
    task automatic issue(input logic action, input logic signed [KW-1:0] key,
                         input bit typed, input t_pq_result typed_result);
        t_pq_result predicted;
        start    <= 1'b1;
        i_action <= action;
        i_key_in <= key;
        do @(posedge i_clk); while (!(start && !busy));
        predicted = apply_to_model(action, key);
        pending_results.push_back(typed ? typed_result : predicted);
        txn_count++;
    endtask

    // Sender pacing: bursts of back-to-back transactions, then a random gap
    // during which the payload ports carry junk.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                start    <= 1'b0;
                i_action <= 1'($urandom);
                i_key_in <= KW'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_pq_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, fill_level", -1, int'(o_fill_level));
            end else begin
                want = pending_results.pop_front();
                if (o_key_out !== want.key_out)
                    flag_mismatch("key_out", want.key_out, o_key_out);
                if (o_key_valid !== want.key_valid)
                    flag_mismatch("key_valid", want.key_valid, o_key_valid);
                if (o_underflow !== want.underflow)
                    flag_mismatch("underflow", want.underflow, o_underflow);
                if (o_overflow !== want.overflow)
                    flag_mismatch("overflow", want.overflow, o_overflow);
                if (o_fill_level !== want.fill_level)
                    flag_mismatch("fill_level", want.fill_level, o_fill_level);
            end
        end
    end

    initial begin
        int         waited;
        int         segment_left;
        int         enqueue_pct;
        logic       action;
        t_pq_result none;

        none = '0;

        // Empty queue, extreme keys, equal keys, a full queue and an
        // enqueue that must be dropped.
        add_row(ACT_DEQUEUE, 16'sh5A5A, 1, '0, 0, 1, 0, 0);
        add_row(ACT_ENQUEUE, KEY_MAX,   1, '0, 0, 0, 0, 1);
        add_row(ACT_ENQUEUE, KEY_MIN,   1, '0, 0, 0, 0, 2);
        add_row(ACT_ENQUEUE, 16'sh0000, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'shFFFF, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'sh0000, 0, '0, 0, 0, 0, 0);
        add_row(ACT_DEQUEUE, 16'sh0000, 1, KEY_MIN, 1, 0, 0, 4);
        add_row(ACT_ENQUEUE, KEY_MIN,   0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, KEY_MAX,   0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'sh7FFE, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'sh0001, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'shFFFE, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'sh5555, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'shAAAA, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'sh0100, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'shFF00, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'sh8001, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'sh00FF, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'sh1234, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'sh8000, 1, '0, 0, 0, 1, spq_pkg::CAPACITY);
        add_row(ACT_DEQUEUE, 16'sh7777, 1, KEY_MIN, 1, 0, 0, spq_pkg::CAPACITY - 1);
        add_row(ACT_DEQUEUE, 16'sh0000, 0, '0, 0, 0, 0, 0);
        add_row(ACT_ENQUEUE, 16'sh0005, 0, '0, 0, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            issue(directed_rows[i].action, directed_rows[i].key, directed_rows[i].typed,
                  directed_rows[i].result);
            pace();
        end

        // Random part: segments that lean toward filling, draining or neither,
        // so the queue keeps swinging between empty and full.
        segment_left = 0;
        enqueue_pct  = 50;
        for (int n = 0; n < RANDOM_TXNS; n++) begin
            if (segment_left == 0) begin
                segment_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0:       enqueue_pct = 85;
                    1:       enqueue_pct = 15;
                    default: enqueue_pct = 50;
                endcase
            end
            segment_left--;
            action = ($urandom_range(0, 99) < enqueue_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
            issue(action, pick_key(), 1'b0, none);
            pace();
        end

        start  <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            $display("%0d results never arrived", pending_results.size());

        $display("Ran %0d transactions: %0d keys dequeued, %0d underflows, %0d overflows.",
                 txn_count, keys_returned, underflows, overflows);
        $display("Field mismatches counted: %0d.", mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timed out waiting for the queue to finish.");
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sorted_priority_queue.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_dpath.sv
rtl/core/sorted_priority_queue.sv
verif/sorted_priority_queue_tb.sv
